FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b in a later cycle
`define ASSERT_IMPL_2(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> ##1 (b)) \
        else $error("assertion failed");

`endif

FILE: rtl/hsc_pkg.sv
// ---------------------------------------------------------------------------
// hsc_pkg
// Types, constants and bit functions for the 16/11 SECDED codec.
// ---------------------------------------------------------------------------
package hsc_pkg;

    localparam logic [15:0] MASK_P0  = 16'hAAAA;
    localparam logic [15:0] MASK_P1  = 16'h6666;
    localparam logic [15:0] MASK_P2  = 16'h1E1E;
    localparam logic [15:0] MASK_P3  = 16'h01FE;
    localparam logic [15:0] MASK_LO  = 16'h00FE;
    localparam logic [15:0] MASK_MID = 16'h0E00;
    localparam logic [15:0] MASK_HI  = 16'h2000;

    typedef enum logic [0:0] {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_ONE = 2'd1,
        ST_BAD = 2'd2
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [10:0] plain_data;
        logic [15:0] codeword;
    } t_in_item;

    typedef struct packed {
        logic [15:0] encoded_word;
        logic [10:0] decoded_data;
        t_status     status;
    } t_out_item;

    function automatic logic [15:0] place_data(input logic [10:0] d);
        return {2'b00, d[10], 1'b0, d[9:7], 1'b0, d[6:0], 1'b0};
    endfunction

    function automatic logic [10:0] take_data(input logic [15:0] w);
        return {w[13], w[11:9], w[7:1]};
    endfunction

    function automatic logic [3:0] syndrome(input logic [15:0] w);
        return {^(w & MASK_P3), ^(w & MASK_P2), ^(w & MASK_P1), ^(w & MASK_P0)};
    endfunction

endpackage

FILE: rtl/hamming_secded_16_11_codec.sv
// Start loads the input register; the result register drives o_valid.
// Throughput: one transaction per cycle; an input register and a result
// register hold one transaction each, with XOR trees between them.
// Reset: synchronous, active low; busy is high while in reset and in the
// cycle after it, and no result is strobed. The receiver cannot stall.
// ---------------------------------------------------------------------------
// hamming_secded_16_11_codec
// Extended Hamming SECDED encoder and decoder, 11 data bits in 16.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hamming_secded_16_11_codec
    import hsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    logic      r_ready;
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    t_out_item n_out;

    logic [15:0] enc_base;
    logic [15:0] enc_par;
    logic [3:0]  synd;
    logic        odd_par;
    logic [3:0]  flip_pos;
    logic [15:0] fixed_word;

    logic        res_bad;
    logic        res_zero;
    logic        res_enc;
    logic        res_even;

    assign busy = !r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready   <= 1'b0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_ready   <= 1'b1;
            r_in_vld  <= start && r_ready;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && r_ready) begin
            r_in <= i_item;
        end
        r_out <= n_out;
    end

    // parity bits sit only inside their own check mask
    always_comb begin
        enc_base     = place_data(r_in.plain_data);
        enc_par      = enc_base;
        enc_par[15]  = ^(enc_base & MASK_P0);
        enc_par[14]  = ^(enc_base & MASK_P1);
        enc_par[12]  = ^(enc_base & MASK_P2);
        enc_par[8]   = ^(enc_base & MASK_P3);
        enc_par[0]   = ^enc_par[15:1];
    end

    always_comb begin
        synd       = syndrome(r_in.codeword);
        odd_par    = ^r_in.codeword;
        flip_pos   = 4'(5'd16 - {1'b0, synd});
        fixed_word = r_in.codeword;
        if (odd_par) begin
            fixed_word = r_in.codeword ^ (16'd1 << flip_pos);
        end
    end

    always_comb begin
        n_out = '0;
        case (t_op'(r_in.kind))
            OP_ENCODE: begin
                n_out.encoded_word = enc_par;
                n_out.status       = ST_OK;
            end
            OP_DECODE: begin
                if (synd != 4'd0 && !odd_par) begin
                    n_out.status = ST_BAD;
                end else begin
                    n_out.decoded_data = take_data(fixed_word);
                    n_out.status       = odd_par ? ST_ONE : ST_OK;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    assign res_bad  = o_valid && o_result.status == ST_BAD;
    assign res_zero = o_result.decoded_data == 11'd0 && o_result.encoded_word == 16'd0;
    assign res_enc  = o_valid && o_result.encoded_word != 16'd0;
    assign res_even = o_result.status == ST_OK && !(^o_result.encoded_word);

    `ASSERT_IMPL_2(a_start_to_strobe, i_clk, i_rst_n, start && !busy, o_valid)
    `ASSERT_IMPL(a_bad_zero, i_clk, i_rst_n, res_bad, res_zero)
    `ASSERT_IMPL(a_enc_even, i_clk, i_rst_n, res_enc, res_even)

endmodule

FILE: verif/tb_hamming_secded_16_11_codec.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_hamming_secded_16_11_codec
// Self-checking bench for the 16/11 SECDED codec. Encode and decode
// transactions, directed corner words then random ones with injected bit
// flips, are pushed through the start/busy port with random gaps. Every
// strobed result is checked field by field against an in-bench codec.
// ---------------------------------------------------------------------------
module tb_hamming_secded_16_11_codec;
    import hsc_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 450;

    localparam logic [3:0][15:0] CHECK_MASKS = {MASK_P3, MASK_P2, MASK_P1, MASK_P0};

    typedef struct {
        logic     hold_off;
        t_in_item item;
    } t_pending;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;

    t_pending  pending_items[$];
    t_out_item expected_results[$];
    int        gap_left    = 0;
    int        burst_left  = 0;
    int        stall_count = 0;
    int        errors      = 0;

    hamming_secded_16_11_codec dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // word bit that carries data bit k
    function automatic int data_bit(input int k);
        return (k < 7) ? k + 1 : (k < 10) ? k + 2 : 13;
    endfunction

    function automatic logic [15:0] secded_encode(input logic [10:0] data);
        logic [15:0] word;
        word = '0;
        for (int k = 0; k < 11; k++) word[data_bit(k)] = data[k];
        for (int i = 0; i < 4; i++) begin
            if (^(word & CHECK_MASKS[i])) word[16 - (1 << i)] = 1'b1;
        end
        word[0] = ^word;
        return word;
    endfunction

    function automatic t_out_item secded_decode(input logic [15:0] word);
        t_out_item  res;
        logic [3:0] syn;
        logic       odd;
        int         flip;
        res = '0;
        for (int i = 0; i < 4; i++) syn[i] = ^(word & CHECK_MASKS[i]);
        odd = ^word;
        if (syn != 4'd0 && !odd) begin
            res.status = ST_BAD;
        end else begin
            if (syn != 4'd0 || odd) begin
                flip = (syn != 4'd0) ? 16 - int'(syn) : 0;
                word[flip] = ~word[flip];
                res.status = ST_ONE;
            end
            for (int k = 0; k < 11; k++) res.decoded_data[k] = word[data_bit(k)];
        end
        return res;
    endfunction

    function automatic t_out_item codec_predict(input t_in_item item);
        t_out_item res;
        if (item.kind == OP_DECODE) begin
            res = secded_decode(item.codeword);
        end else begin
            res = '0;
            res.encoded_word = secded_encode(item.plain_data);
        end
        return res;
    endfunction

    task automatic add_item(input logic kind, input logic [10:0] data,
                            input logic [15:0] word, input logic hold_off);
        t_pending p;
        p.hold_off        = hold_off;
        p.item.kind       = kind;
        p.item.plain_data = data;
        p.item.codeword   = word;
        pending_items.push_back(p);
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    // driver
    always @(posedge i_clk) begin
        logic took;
        int   pick;
        took = start && !busy;
        if (took) begin
            expected_results.push_back(codec_predict(i_item));
            void'(pending_items.pop_front());
            pick = $urandom_range(0, 99);
            if (burst_left > 0) begin
                burst_left--;
                gap_left = 0;
            end else if (pick < 4) begin
                burst_left = $urandom_range(20, 60);
                gap_left = 0;
            end else if (pick < 55) begin
                gap_left = 0;
            end else if (pick < 90) begin
                gap_left = $urandom_range(1, 3);
            end else begin
                gap_left = $urandom_range(4, 25);
            end
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (took || !start) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         (!pending_items[0].hold_off || expected_results.size() == 0)) begin
                start  <= 1'b1;
                i_item <= pending_items[0].item;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result %h with no transaction outstanding", $time, o_result);
            end else begin
                want = expected_results.pop_front();
                if (o_result.encoded_word !== want.encoded_word)
                    report_mismatch("encoded_word", want.encoded_word, o_result.encoded_word);
                if (o_result.decoded_data !== want.decoded_data)
                    report_mismatch("decoded_data", 16'(want.decoded_data),
                                    16'(o_result.decoded_data));
                if (o_result.status !== want.status)
                    report_mismatch("status", 16'(want.status), 16'(o_result.status));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid === 1'b1) stall_count = 0;
            else stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] good;
        logic [15:0] word;
        logic [10:0] data;
        int          pick;
        int          bit_a;
        int          bit_b;

        // directed corners
        add_item(OP_ENCODE, 11'h000, 16'h0000, 1'b0);
        add_item(OP_ENCODE, 11'h7FF, 16'h0000, 1'b0);
        add_item(OP_ENCODE, 11'h555, 16'hFFFF, 1'b0);
        add_item(OP_ENCODE, 11'h2AA, 16'hA5A5, 1'b0);
        add_item(OP_ENCODE, 11'h001, 16'h0000, 1'b0);
        add_item(OP_ENCODE, 11'h400, 16'h0000, 1'b0);
        add_item(OP_DECODE, 11'h000, 16'h0000, 1'b0);
        add_item(OP_DECODE, 11'h7FF, 16'hFFFF, 1'b0);
        good = secded_encode(11'h5A3);
        add_item(OP_DECODE, 11'h7FF, good, 1'b0);
        add_item(OP_DECODE, 11'h000, good ^ 16'h0001, 1'b0);
        good = secded_encode(11'h3C7);
        add_item(OP_DECODE, 11'h000, good ^ 16'h8000, 1'b0);
        add_item(OP_DECODE, 11'h000, good ^ 16'h2000, 1'b0);
        add_item(OP_DECODE, 11'h000, good ^ 16'h0100, 1'b0);
        add_item(OP_DECODE, 11'h000, good ^ 16'h0002, 1'b0);
        add_item(OP_DECODE, 11'h000, good ^ 16'h1008, 1'b0);
        add_item(OP_DECODE, 11'h000, good ^ 16'h0201, 1'b0);
        good = secded_encode(11'h7FF);
        add_item(OP_DECODE, 11'h000, good, 1'b0);
        add_item(OP_DECODE, 11'h000, good ^ 16'h4000, 1'b0);
        add_item(OP_DECODE, 11'h000, good ^ 16'hC000, 1'b0);

        // random: encodes, clean words, single and double flips, raw words
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            data  = 11'($urandom_range(0, 2047));
            word  = 16'($urandom_range(0, 65535));
            good  = secded_encode(11'($urandom_range(0, 2047)));
            bit_a = $urandom_range(0, 15);
            bit_b = (bit_a + $urandom_range(1, 15)) % 16;
            pick  = $urandom_range(0, 99);
            if (pick < 35) begin
                add_item(OP_ENCODE, data, word, n == 0 || n == 220);
            end else begin
                if (pick < 55) word = good;
                else if (pick < 80) word = good ^ (16'h1 << bit_a);
                else if (pick < 95) word = good ^ (16'h1 << bit_a) ^ (16'h1 << bit_b);
                add_item(OP_DECODE, data, word, n == 0 || n == 220);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
